/* src/rmts_pkg.sv */
`default_nettype none

package rmts_pkg;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_COMPLETE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_GRANTED   = 3'd4
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [7:0]         process_id;
        logic signed [15:0] start_time;
        logic [14:0]        period;
        logic               repeat_req;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [7:0]         granted_id;
        logic signed [15:0] head_time;
        logic [2:0]         occupancy;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_TICK,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_CPL_RD,
        S_CPL_WR
    } t_state;

    typedef struct packed {
        logic load;
        logic set_empty;
        logic add;
        logic walk_tick;
        logic walk_min;
        logic swap_a;
        logic swap_b;
        logic cpl_rd;
        logic cpl_wr;
        logic fin;
    } t_ctl_cmd;

    typedef struct packed {
        logic empty;
        logic walk_done;
    } t_ctl_stat;

endpackage

`default_nettype wire

/* src/ring_min_time_task_scheduler.sv */
// Per word, add runs S_ADD; complete S_CPL_RD, S_CPL_WR; tick walks in S_TICK;
// dispatch S_SCAN, S_SWAP_A, S_SWAP_B; empty dispatch or complete only S_CPL_WR.
// Tick and dispatch walk the ring through the single read port of the entry
// RAM, one entry a cycle; the next word may start in the strobe cycle.
// The receiver cannot stall: each result word is shown for one cycle only.
// Synchronous active-low reset empties the ring at once; entries need no clearing.
`default_nettype none

module ring_min_time_task_scheduler #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rmts_pkg::t_item   i_item,
    output logic                   o_done,
    output rmts_pkg::t_result      o_result
);

    rmts_pkg::t_ctl_cmd  w_cmd;
    rmts_pkg::t_ctl_stat w_stat;
    rmts_pkg::t_result   w_result;

    rmts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.operation),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    rmts_dpath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (w_result)
    );

    assign o_result = w_result;

`ifndef ASSERT_OFF
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_plain_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == rmts_pkg::ST_OK ||
                    o_result.status == rmts_pkg::ST_FULL ||
                    o_result.status == rmts_pkg::ST_EMPTY))
        |-> (o_result.granted_id == '0 && o_result.head_time == '0))
        else $error("non-dispatch result carries id or time");
`endif

endmodule

`default_nettype wire

/* src/rmts_ram.sv */
`default_nettype none

module rmts_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/rmts_ctrl.sv */
`default_nettype none

module rmts_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire rmts_pkg::t_op        i_op,
    input  wire rmts_pkg::t_ctl_stat  i_stat,
    output logic                      o_busy,
    output rmts_pkg::t_ctl_cmd        o_cmd
);

    rmts_pkg::t_state r_state;
    rmts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != rmts_pkg::S_IDLE);
        unique case (r_state)
            rmts_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_op)
                        rmts_pkg::OP_ADD: begin
                            n_state = rmts_pkg::S_ADD;
                        end
                        rmts_pkg::OP_TICK: begin
                            n_state = rmts_pkg::S_TICK;
                        end
                        rmts_pkg::OP_DISPATCH: begin
                            if (i_stat.empty) begin
                                o_cmd.set_empty = 1'b1;
                                n_state = rmts_pkg::S_CPL_WR;
                            end else begin
                                n_state = rmts_pkg::S_SCAN;
                            end
                        end
                        rmts_pkg::OP_COMPLETE: begin
                            if (i_stat.empty) begin
                                o_cmd.set_empty = 1'b1;
                                n_state = rmts_pkg::S_CPL_WR;
                            end else begin
                                n_state = rmts_pkg::S_CPL_RD;
                            end
                        end
                        default: begin
                            n_state = rmts_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rmts_pkg::S_ADD: begin
                o_cmd.add = 1'b1;
                o_cmd.fin = 1'b1;
                n_state   = rmts_pkg::S_IDLE;
            end
            rmts_pkg::S_TICK: begin
                o_cmd.walk_tick = 1'b1;
                if (i_stat.walk_done) begin
                    o_cmd.fin = 1'b1;
                    n_state   = rmts_pkg::S_IDLE;
                end
            end
            rmts_pkg::S_SCAN: begin
                o_cmd.walk_min = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = rmts_pkg::S_SWAP_A;
                end
            end
            rmts_pkg::S_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state      = rmts_pkg::S_SWAP_B;
            end
            rmts_pkg::S_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                o_cmd.fin    = 1'b1;
                n_state      = rmts_pkg::S_IDLE;
            end
            rmts_pkg::S_CPL_RD: begin
                o_cmd.cpl_rd = 1'b1;
                n_state      = rmts_pkg::S_CPL_WR;
            end
            rmts_pkg::S_CPL_WR: begin
                // An empty dispatch or complete also passes through here, with
                // the pop suppressed, only to publish its word.
                o_cmd.cpl_wr = !i_stat.empty;
                o_cmd.fin    = 1'b1;
                n_state      = rmts_pkg::S_IDLE;
            end
            default: begin
                n_state = rmts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/rmts_dpath.sv */
`default_nettype none

module rmts_dpath #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rmts_pkg::t_ctl_cmd   i_cmd,
    output rmts_pkg::t_ctl_stat       o_stat,
    input  wire rmts_pkg::t_item      i_item,
    output logic                      o_done,
    output rmts_pkg::t_result         o_result
);

    localparam int IW = $clog2(SLOTS);
    localparam int DW = 8 + TIME_BITS + 15;
    localparam int SW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;
    localparam longint TMAX_L = (longint'(1) <<< (TIME_BITS - 1)) - longint'(1);
    localparam logic signed [SW-1:0] TMAX_W = SW'(TMAX_L);
    localparam logic signed [SW-1:0] TMIN_W = SW'(-TMAX_L - longint'(1));
    localparam logic signed [TIME_BITS-1:0] TMIN_T = TIME_BITS'(-TMAX_L - longint'(1));
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    // Builds the stored word of an enqueued task: time clamped into range,
    // then the period added with saturation at the top of the range.
    function automatic logic [DW-1:0] enq_word(
        input logic [7:0]           id,
        input logic signed [SW-1:0] t,
        input logic [14:0]          per
    );
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] s;
        c = t;
        if (c < TMIN_W) c = TMIN_W;
        if (c > TMAX_W) c = TMAX_W;
        s = c + SW'($signed({1'b0, per}));
        if (s > TMAX_W) s = TMAX_W;
        return {id, s[TIME_BITS-1:0], per};
    endfunction

    logic [IW-1:0]                r_head;
    logic [IW-1:0]                r_tail;
    logic [IW-1:0]                r_ptr;
    logic [IW-1:0]                r_rd_addr;
    logic                         r_rd_vld;
    logic [IW-1:0]                r_best_idx;
    logic [7:0]                   r_best_id;
    logic signed [TIME_BITS-1:0]  r_best_time;
    logic [14:0]                  r_best_per;
    logic [DW-1:0]                r_head_word;
    logic [7:0]                   r_pid;
    logic signed [15:0]           r_st;
    logic [14:0]                  r_per;
    logic                         r_rep;
    rmts_pkg::t_status            r_status;
    logic [7:0]                   r_gid;
    logic [15:0]                  r_htime;
    logic                         r_done;
    rmts_pkg::t_result            r_result;

    logic                         w_full;
    logic                         w_empty;
    logic [DW-1:0]                w_q;
    logic [7:0]                   w_q_id;
    logic signed [TIME_BITS-1:0]  w_q_time;
    logic [14:0]                  w_q_per;
    logic [TIME_BITS-1:0]         w_q_dec;
    logic                         w_walk;
    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    logic [DW-1:0]                w_wdata;
    logic                         w_re;
    logic [IW-1:0]                w_raddr;
    logic signed [SW-1:0]         w_best_ext;
    logic                         w_ready;
    logic [IW-1:0]                w_head_next;
    logic [IW-1:0]                w_tail_next;
    logic [IW-1:0]                w_count_next;
    logic [IW+2:0]                w_count_next_x;

    assign w_full   = (nxt(r_tail) == r_head);
    assign w_empty  = (r_head == r_tail);
    assign w_walk   = i_cmd.walk_tick || i_cmd.walk_min;

    assign w_q_id   = w_q[DW-1 -: 8];
    assign w_q_time = $signed(w_q[15 +: TIME_BITS]);
    assign w_q_per  = w_q[14:0];
    assign w_q_dec  = (w_q_time == TMIN_T) ? w_q_time : w_q_time - TIME_BITS'(1);

    assign w_best_ext = SW'(r_best_time);
    assign w_ready    = r_best_time[TIME_BITS-1] || (r_best_time == '0);

    assign o_stat.empty     = w_empty;
    assign o_stat.walk_done = (r_ptr == r_tail) && !r_rd_vld;

    // The walk reads one entry ahead of the one being processed.
    assign w_re    = (w_walk && (r_ptr != r_tail)) || i_cmd.cpl_rd;
    assign w_raddr = i_cmd.cpl_rd ? r_head : r_ptr;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_tail;
        w_wdata = enq_word(r_pid, SW'(r_st), r_per);
        if (i_cmd.add) begin
            w_we = !w_full;
        end else if (i_cmd.walk_tick) begin
            w_we    = r_rd_vld;
            w_waddr = r_rd_addr;
            w_wdata = {w_q_id, w_q_dec, w_q_per};
        end else if (i_cmd.swap_a) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            w_wdata = r_head_word;
        end else if (i_cmd.swap_b) begin
            w_we    = 1'b1;
            w_waddr = r_head;
            w_wdata = {r_best_id, r_best_time, r_best_per};
        end else if (i_cmd.cpl_wr) begin
            w_we    = r_rep && !w_full;
            w_wdata = enq_word(w_q_id, SW'(w_q_time), w_q_per);
        end
    end

    rmts_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.fin;
            if (i_cmd.load) begin
                r_ptr    <= r_head;
                r_rd_vld <= 1'b0;
            end else if (w_walk) begin
                if (r_ptr != r_tail) begin
                    r_ptr    <= nxt(r_ptr);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            if (i_cmd.add && !w_full) begin
                r_tail <= nxt(r_tail);
            end
            if (i_cmd.cpl_wr) begin
                if (r_rep && !w_full) begin
                    r_tail <= nxt(r_tail);
                end
                r_head <= nxt(r_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid    <= i_item.process_id;
            r_st     <= i_item.start_time;
            r_per    <= i_item.period;
            r_rep    <= i_item.repeat_req;
            r_status <= i_cmd.set_empty ? rmts_pkg::ST_EMPTY : rmts_pkg::ST_OK;
            r_gid    <= '0;
            r_htime  <= '0;
        end
        if (w_walk) begin
            r_rd_addr <= r_ptr;
        end
        // The head entry is read first, so it seeds the search; later entries
        // win only when strictly earlier, keeping the first minimum in ring order.
        if (i_cmd.walk_min && r_rd_vld) begin
            if (r_rd_addr == r_head) begin
                r_head_word <= w_q;
                r_best_idx  <= r_rd_addr;
                r_best_id   <= w_q_id;
                r_best_time <= w_q_time;
                r_best_per  <= w_q_per;
            end else if (w_q_time < r_best_time) begin
                r_best_idx  <= r_rd_addr;
                r_best_id   <= w_q_id;
                r_best_time <= w_q_time;
                r_best_per  <= w_q_per;
            end
        end
        if (i_cmd.add && w_full) begin
            r_status <= rmts_pkg::ST_FULL;
        end
        if (i_cmd.swap_b) begin
            r_htime <= w_best_ext[15:0];
            if (w_ready) begin
                r_status <= rmts_pkg::ST_GRANTED;
                r_gid    <= r_best_id;
            end else begin
                r_status <= rmts_pkg::ST_NOT_READY;
            end
        end
        if (i_cmd.cpl_wr && r_rep && w_full) begin
            r_status <= rmts_pkg::ST_FULL;
        end
        if (i_cmd.fin) begin
            r_result.status     <= (i_cmd.swap_b) ?
                                   (w_ready ? rmts_pkg::ST_GRANTED : rmts_pkg::ST_NOT_READY) :
                                   (i_cmd.add && w_full) ? rmts_pkg::ST_FULL :
                                   (i_cmd.cpl_wr && r_rep && w_full) ? rmts_pkg::ST_FULL :
                                   r_status;
            r_result.granted_id <= (i_cmd.swap_b && w_ready) ? r_best_id : r_gid;
            r_result.head_time  <= i_cmd.swap_b ? $signed(w_best_ext[15:0]) : $signed(r_htime);
            r_result.occupancy  <= w_count_next_x[2:0];
        end
    end

    // The occupancy in the result word is taken in the finishing cycle, so the
    // pointer update of that same cycle must be folded in.
    always_comb begin
        w_head_next = r_head;
        w_tail_next = r_tail;
        if (i_cmd.add && !w_full) begin
            w_tail_next = nxt(r_tail);
        end
        if (i_cmd.cpl_wr) begin
            if (r_rep && !w_full) begin
                w_tail_next = nxt(r_tail);
            end
            w_head_next = nxt(r_head);
        end
    end

    assign w_count_next   = (w_tail_next >= w_head_next) ? w_tail_next - w_head_next
                          : IW'(int'(w_tail_next) + SLOTS - int'(w_head_next));
    assign w_count_next_x = (IW + 3)'(w_count_next);

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* dv/scheduler_checker.sv */
module scheduler_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire rmts_pkg::t_item   i_item,
    input  wire logic              i_done,
    input  wire rmts_pkg::t_result i_result,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS = 8;
    localparam int TIME_MAX   = 32767;
    localparam int TIME_MIN   = -32768;

    logic [7:0]  ring_id     [RING_SLOTS];
    int          ring_time   [RING_SLOTS];
    logic [14:0] ring_period [RING_SLOTS];
    int          head_idx = 0;
    int          tail_idx = 0;

    rmts_pkg::t_result expected_results [$];
    int          error_count = 0;
    int          result_count = 0;

    assign o_errors = error_count;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    function automatic int ring_next(input int idx);
        return (idx + 1) % RING_SLOTS;
    endfunction

    // Enqueues at the tail with the period added, saturating at the top of the range.
    function automatic bit push_task(input logic [7:0] id, input int t, input logic [14:0] per);
        int sum;
        if (ring_next(tail_idx) == head_idx)
            return 1'b0;
        sum = t + int'(per);
        if (sum > TIME_MAX)
            sum = TIME_MAX;
        ring_id[tail_idx]     = id;
        ring_time[tail_idx]   = sum;
        ring_period[tail_idx] = per;
        tail_idx              = ring_next(tail_idx);
        return 1'b1;
    endfunction

    task automatic predict_schedule(input rmts_pkg::t_item w, output rmts_pkg::t_result r);
        int          best;
        int          idx;
        logic [7:0]  tid;
        int          tt;
        logic [14:0] tp;
        r        = '0;
        r.status = rmts_pkg::ST_OK;
        case (w.operation)
            rmts_pkg::OP_ADD: begin
                if (!push_task(w.process_id, int'($signed(w.start_time)), w.period))
                    r.status = rmts_pkg::ST_FULL;
            end
            rmts_pkg::OP_TICK: begin
                for (idx = head_idx; idx != tail_idx; idx = ring_next(idx))
                    if (ring_time[idx] > TIME_MIN)
                        ring_time[idx]--;
            end
            rmts_pkg::OP_DISPATCH: begin
                if (head_idx == tail_idx) begin
                    r.status = rmts_pkg::ST_EMPTY;
                end else begin
                    // Strict compare keeps the earliest entry in ring order on a tie.
                    best = head_idx;
                    for (idx = ring_next(head_idx); idx != tail_idx; idx = ring_next(idx))
                        if (ring_time[idx] < ring_time[best])
                            best = idx;
                    tid = ring_id[best];
                    tt  = ring_time[best];
                    tp  = ring_period[best];
                    ring_id[best]         = ring_id[head_idx];
                    ring_time[best]       = ring_time[head_idx];
                    ring_period[best]     = ring_period[head_idx];
                    ring_id[head_idx]     = tid;
                    ring_time[head_idx]   = tt;
                    ring_period[head_idx] = tp;
                    r.head_time = tt[15:0];
                    if (tt <= 0) begin
                        r.status     = rmts_pkg::ST_GRANTED;
                        r.granted_id = tid;
                    end else begin
                        r.status = rmts_pkg::ST_NOT_READY;
                    end
                end
            end
            default: begin
                if (head_idx == tail_idx) begin
                    r.status = rmts_pkg::ST_EMPTY;
                end else begin
                    // A failed re-add still pops the head.
                    if (w.repeat_req)
                        if (!push_task(ring_id[head_idx], ring_time[head_idx],
                                       ring_period[head_idx]))
                            r.status = rmts_pkg::ST_FULL;
                    head_idx = ring_next(head_idx);
                end
            end
        endcase
        r.occupancy = 3'((tail_idx - head_idx + RING_SLOTS) % RING_SLOTS);
    endtask

    always @(posedge i_clk) begin : observe
        rmts_pkg::t_result want;
        logic    wrong;
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            expected_results.delete();
        end else begin
            // A result leaving at this edge belongs to an older word than one
            // entering at the same edge, so it is checked first.
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want  = expected_results.pop_front();
                    wrong = (i_result.status !== want.status)
                         || (i_result.granted_id !== want.granted_id)
                         || (i_result.head_time !== want.head_time)
                         || (i_result.occupancy !== want.occupancy);
                    if (wrong)
                        report_mismatch($sformatf(
                            {"result %0d got st=%0d id=%h t=%0d occ=%0d, ",
                             "exp st=%0d id=%h t=%0d occ=%0d"},
                            result_count, i_result.status, i_result.granted_id,
                            i_result.head_time, i_result.occupancy, want.status,
                            want.granted_id, want.head_time, want.occupancy));
                end
                result_count++;
            end
            if (i_start && !i_busy) begin
                predict_schedule(i_item, want);
                expected_results.push_back(want);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* dv/ring_min_time_task_scheduler_tb.sv */
module ring_min_time_task_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 200000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    rmts_pkg::t_item   i_item  = '0;
    logic              busy;
    logic              o_done;
    rmts_pkg::t_result o_result;

    int      errors;
    int      pending;
    int      cycles = 0;
    bit      no_idle = 1'b0;
    int      mode_left = 0;

    ring_min_time_task_scheduler u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    scheduler_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic rmts_pkg::t_item make_word(input rmts_pkg::t_op op,
                                                  input logic [7:0] pid,
                                                  input logic [15:0] st,
                                                  input logic [14:0] per,
                                                  input logic rep);
        rmts_pkg::t_item w;
        w.operation  = op;
        w.process_id = pid;
        w.start_time = st;
        w.period     = per;
        w.repeat_req = rep;
        return w;
    endfunction

    // Mostly times and periods near zero so that grants and ties are common,
    // with the occasional word over the full range.
    function automatic rmts_pkg::t_item random_word(input rmts_pkg::t_op op);
        rmts_pkg::t_item w;
        w.operation  = op;
        w.process_id = 8'($urandom);
        w.repeat_req = 1'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            w.start_time = 16'($urandom);
            w.period     = 15'($urandom);
        end else begin
            w.start_time = 16'($urandom_range(0, 40)) - 16'd20;
            w.period     = 15'($urandom_range(0, 12));
        end
        return w;
    endfunction

    // Holds start high across back-to-back words; it drops only for a gap or a drain.
    task automatic send_word(input rmts_pkg::t_item w);
        int gap;
        if (mode_left <= 0) begin
            no_idle   = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(10, 40);
        end
        mode_left--;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int  sent;
        int  pick;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty ring first, then fill it with range extremes until it is full.
        send_word(make_word(rmts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_COMPLETE, 8'hFF, 16'hFFFF, 15'h7FFF, 1'b1));
        send_word(make_word(rmts_pkg::OP_TICK,     8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'h00, 16'h8000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_TICK,     8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'hFF, 16'h7FFF, 15'h7FFF, 1'b1));
        send_word(make_word(rmts_pkg::OP_ADD,      8'h5A, 16'd100,  15'h7FFF, 1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'hA5, 16'hFFFF, 15'd1,    1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'h3C, 16'd5,    15'd0,    1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'hC3, 16'h8000, 15'h7FFF, 1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'h11, 16'd0,    15'd0,    1'b0));
        send_word(make_word(rmts_pkg::OP_ADD,      8'h22, 16'd1,    15'd1,    1'b0));
        // Complete on a full ring without a dispatch: the re-add fails.
        send_word(make_word(rmts_pkg::OP_COMPLETE, 8'h00, 16'h0000, 15'h0000, 1'b1));
        send_word(make_word(rmts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_COMPLETE, 8'h00, 16'h0000, 15'h0000, 1'b1));
        send_word(make_word(rmts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_COMPLETE, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_COMPLETE, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_COMPLETE, 8'h00, 16'h0000, 15'h0000, 1'b1));
        send_word(make_word(rmts_pkg::OP_TICK,     8'h00, 16'h0000, 15'h0000, 1'b0));
        send_word(make_word(rmts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 15'h0000, 1'b0));
        drain_results();

        // Dispatch followed by complete is the normal task cycle; the rest is
        // adds, ticks and unpaired dispatches or completes.
        while (sent < RANDOM_WORDS) begin
            if (!paused && sent >= RANDOM_WORDS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_word(random_word(rmts_pkg::OP_ADD));
                sent++;
            end else if (pick < 50) begin
                send_word(random_word(rmts_pkg::OP_TICK));
                sent++;
            end else if (pick < 80) begin
                send_word(random_word(rmts_pkg::OP_DISPATCH));
                send_word(random_word(rmts_pkg::OP_COMPLETE));
                sent += 2;
            end else if (pick < 90) begin
                send_word(random_word(rmts_pkg::OP_DISPATCH));
                sent++;
            end else begin
                send_word(random_word(rmts_pkg::OP_COMPLETE));
                sent++;
            end
        end
        drain_results();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/rmts_pkg.sv
src/rmts_ram.sv
src/rmts_ctrl.sv
src/rmts_dpath.sv
src/ring_min_time_task_scheduler.sv
dv/scheduler_checker.sv
dv/ring_min_time_task_scheduler_tb.sv
